>>> rtl/ffba_pkg.sv
// ============================================================================
// ffba_pkg
// Shared constants and types for the first-fit block allocator.
// ============================================================================
package ffba_pkg;

   // Default table depth and per-block header size.
   localparam int DefMaxBlocks  = 64;
   localparam int DefHeaderBytes = 12;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HEAP_BASE  = 2'd0;
   localparam logic [1:0] CSR_HEAP_BYTES = 2'd1;

   // Reset value of the heap size register.
   localparam logic [31:0] HeapBytesReset = 32'd1048576;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_RD_CUR,
      OP_LATCH_CUR,
      OP_MERGE_CHK,
      OP_SH_RD,
      OP_SH_WR,
      OP_CHECK,
      OP_IN_RD,
      OP_IN_WR,
      OP_RL_RD,
      OP_RL_CHK,
      OP_RESP
   } op_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic pending;
      logic range_bad;
      logic merge;
      logic sh_more;
      logic fit;
      logic split;
      logic visit_next;
      logic in_more;
      logic rl_hit;
      logic rsp_free;
   } dp_status_type;

endpackage

>>> rtl/ffba_ctrl.sv
// ============================================================================
// ffba_ctrl
// Sequencer for the allocator: walks, merges, shifts, splits and responds.
// ============================================================================
module ffba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_kind,
   input  ffba_pkg::dp_status_type st,
   output ffba_pkg::op_type       op,
   output logic                   req_stall
);
   import ffba_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_LOAD  = 13'b0000000000010,
      S_A_RD  = 13'b0000000000100,
      S_A_NX  = 13'b0000000001000,
      S_A_MG  = 13'b0000000010000,
      S_SH_RD = 13'b0000000100000,
      S_SH_WR = 13'b0000001000000,
      S_CHK   = 13'b0000010000000,
      S_IN_RD = 13'b0000100000000,
      S_IN_WR = 13'b0001000000000,
      S_R_RD  = 13'b0010000000000,
      S_R_CK  = 13'b0100000000000,
      S_RESP  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // A new word is taken only in idle, once any table reload is done.
   assign req_stall = !((state_ff == S_IDLE) && !st.pending);

   // Next state and command.
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (st.pending) begin
               state_in = S_LOAD;
            end else if (req_valid) begin
               op       = OP_START;
               state_in = req_kind ? S_R_RD : S_A_RD;
            end
         end
         S_LOAD: begin
            op       = OP_LOAD;
            state_in = S_IDLE;
         end
         S_A_RD: begin
            op       = OP_RD_CUR;
            state_in = S_A_NX;
         end
         S_A_NX: begin
            op       = OP_LATCH_CUR;
            state_in = S_A_MG;
         end
         S_A_MG: begin
            op       = OP_MERGE_CHK;
            state_in = st.merge ? S_SH_RD : S_CHK;
         end
         S_SH_RD: begin
            op       = OP_SH_RD;
            state_in = st.sh_more ? S_SH_WR : S_CHK;
         end
         S_SH_WR: begin
            op       = OP_SH_WR;
            state_in = S_SH_RD;
         end
         S_CHK: begin
            op = OP_CHECK;
            priority if (st.fit && st.split) begin
               state_in = S_IN_RD;
            end else if (st.fit) begin
               state_in = S_RESP;
            end else if (st.visit_next) begin
               state_in = S_A_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_IN_RD: begin
            op       = OP_IN_RD;
            state_in = st.in_more ? S_IN_WR : S_RESP;
         end
         S_IN_WR: begin
            op       = OP_IN_WR;
            state_in = S_IN_RD;
         end
         S_R_RD: begin
            op       = OP_RL_RD;
            state_in = st.range_bad ? S_RESP : S_R_CK;
         end
         S_R_CK: begin
            op = OP_RL_CHK;
            priority if (st.rl_hit) begin
               state_in = S_RESP;
            end else if (st.visit_next) begin
               state_in = S_R_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            op = OP_RESP;
            if (st.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/ffba_dp.sv
// ============================================================================
// ffba_dp
// Datapath: block table memory, walk registers, free total and result word.
// ============================================================================
module ffba_dp #(
   parameter int MAX_BLOCKS   = ffba_pkg::DefMaxBlocks,
   parameter int HEADER_BYTES = ffba_pkg::DefHeaderBytes
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ffba_pkg::op_type        op,
   output ffba_pkg::dp_status_type st,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_write_data,
   input  logic                    req_kind,
   input  logic [31:0]             req_request_bytes,
   input  logic [31:0]             req_release_address,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [31:0]             rsp_granted_address,
   output logic [31:0]             rsp_free_total
);
   import ffba_pkg::*;

   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int NEED_W = 33;
   localparam int OFS_W  = 34 + IDX_W;
   localparam int FS_W   = 33 + IDX_W;
   localparam logic [CNT_W-1:0]  CntMax = CNT_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0]  CntOne = CNT_W'(1);
   localparam logic [NEED_W-1:0] HdrN   = NEED_W'(HEADER_BYTES);
   localparam logic [OFS_W-1:0]  HdrO   = OFS_W'(HEADER_BYTES);

   // Table memory: bit 32 is the free mark, bits 31:0 the block length.
   logic [32:0] mem [MAX_BLOCKS];
   logic [32:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [32:0] wr_data;
   logic wr_en;

   logic [31:0] base_ff, base_in, bytes_ff, bytes_in;
   logic pending_ff, pending_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [31:0] addr_ff, addr_in, rem_ff, rem_in;
   logic range_bad_ff, range_bad_in;
   logic [OFS_W-1:0] offset_ff, offset_in;
   logic [FS_W-1:0] free_sum_ff, free_sum_in;
   logic [32:0] cur_ff, cur_in;
   status_type code_ff, code_in;
   logic [31:0] grant_ff, grant_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_grant_ff, rsp_grant_in, rsp_free_ff, rsp_free_in;

   logic [31:0] cur_len, rd_len, merge_sat, free_sat;
   logic cur_free, rd_free;
   logic [CNT_W-1:0] i_nx;
   logic [32:0] merge_sum;
   logic [OFS_W-1:0] grant_wide;

   assign cur_len   = cur_ff[31:0];
   assign cur_free  = cur_ff[32];
   assign rd_len    = rd_data_ff[31:0];
   assign rd_free   = rd_data_ff[32];
   assign i_nx      = i_ff + CntOne;
   assign merge_sum = {1'b0, cur_len} + {1'b0, rd_len};
   assign merge_sat = merge_sum[32] ? 32'hFFFF_FFFF : merge_sum[31:0];
   assign free_sat  = (free_sum_ff > FS_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                          : free_sum_ff[31:0];
   assign grant_wide = OFS_W'(base_ff) + offset_ff + HdrO;

   // Status toward the controller.
   always_comb begin
      st.pending    = pending_ff;
      st.range_bad  = range_bad_ff;
      st.merge      = cur_free && (i_nx < cnt_ff) && rd_free;
      st.sh_more    = (j_ff + CntOne) < cnt_ff;
      st.fit        = cur_free && ({1'b0, cur_len} >= need_ff);
      st.split      = ({2'b0, cur_len} > ({1'b0, need_ff} + {1'b0, HdrN}))
                      && (cnt_ff < CntMax);
      st.visit_next = i_nx < cnt_ff;
      st.in_more    = j_ff > i_nx;
      st.rl_hit     = (offset_ff + HdrO) == OFS_W'(addr_ff);
      st.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Memory read address.
   always_comb begin
      unique case (op)
         OP_LATCH_CUR: rd_addr = i_nx[IDX_W-1:0];
         OP_SH_RD:     rd_addr = IDX_W'(j_ff + CntOne);
         OP_IN_RD:     rd_addr = IDX_W'(j_ff - CntOne);
         default:      rd_addr = i_ff[IDX_W-1:0];
      endcase
   end

   // Memory write port.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff[IDX_W-1:0];
      wr_data = rd_data_ff;
      unique case (op)
         OP_LOAD: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {1'b1, bytes_ff};
         end
         OP_MERGE_CHK: begin
            wr_en   = st.merge;
            wr_data = {1'b1, merge_sat};
         end
         OP_SH_WR, OP_IN_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IDX_W-1:0];
         end
         OP_CHECK: begin
            wr_en   = st.fit;
            wr_data = {1'b0, st.split ? need_ff[31:0] : cur_len};
         end
         OP_IN_RD: begin
            wr_en   = !st.in_more;
            wr_addr = i_nx[IDX_W-1:0];
            wr_data = {1'b1, rem_ff};
         end
         OP_RL_CHK: begin
            wr_en   = st.rl_hit;
            wr_data = {1'b1, rd_len};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Next values of the walk and result registers.
   always_comb begin
      base_in      = base_ff;
      bytes_in     = bytes_ff;
      pending_in   = pending_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      need_in      = need_ff;
      addr_in      = addr_ff;
      rem_in       = rem_ff;
      range_bad_in = range_bad_ff;
      offset_in    = offset_ff;
      free_sum_in  = free_sum_ff;
      cur_in       = cur_ff;
      code_in      = code_ff;
      grant_in     = grant_ff;

      // Configuration writes; a new heap size schedules a table reload.
      if (csr_write_enable) begin
         if (csr_index == CSR_HEAP_BASE) begin
            base_in = csr_write_data;
         end else if (csr_index == CSR_HEAP_BYTES) begin
            bytes_in   = csr_write_data;
            pending_in = 1'b1;
         end
      end

      unique case (op)
         OP_LOAD: begin
            pending_in  = 1'b0;
            cnt_in      = CntOne;
            free_sum_in = FS_W'(bytes_ff);
         end
         OP_START: begin
            need_in      = {1'b0, req_request_bytes} + HdrN;
            addr_in      = req_release_address;
            i_in         = '0;
            offset_in    = req_kind ? OFS_W'(base_ff) : '0;
            range_bad_in = (req_release_address < base_ff) ||
                           ({1'b0, req_release_address} >
                            ({1'b0, base_ff} + {1'b0, bytes_ff}));
            code_in      = req_kind ? ST_IGNORED : ST_NOFIT;
            grant_in     = '0;
         end
         OP_LATCH_CUR: begin
            cur_in = rd_data_ff;
         end
         OP_MERGE_CHK: begin
            if (st.merge) begin
               cur_in      = {1'b1, merge_sat};
               free_sum_in = free_sum_ff - FS_W'(merge_sum) + FS_W'(merge_sat);
               j_in        = i_nx;
            end
         end
         OP_SH_RD: begin
            if (!st.sh_more) begin
               cnt_in = cnt_ff - CntOne;
            end
         end
         OP_SH_WR: begin
            j_in = j_ff + CntOne;
         end
         OP_CHECK: begin
            if (st.fit) begin
               free_sum_in = free_sum_ff -
                             FS_W'(st.split ? need_ff[31:0] : cur_len);
               rem_in      = cur_len - need_ff[31:0];
               j_in        = cnt_ff;
               code_in     = ST_DONE;
               grant_in    = grant_wide[31:0];
            end else begin
               offset_in = offset_ff + OFS_W'(cur_len);
               i_in      = i_nx;
            end
         end
         OP_IN_RD: begin
            if (!st.in_more) begin
               cnt_in = cnt_ff + CntOne;
            end
         end
         OP_IN_WR: begin
            j_in = j_ff - CntOne;
         end
         OP_RL_CHK: begin
            if (st.rl_hit) begin
               code_in = ST_DONE;
               if (!rd_free) begin
                  free_sum_in = free_sum_ff + FS_W'(rd_len);
               end
            end else begin
               offset_in = offset_ff + OFS_W'(rd_len);
               i_in      = i_nx;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Output register: holds one finished word while the next item runs.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_free_in   = rsp_free_ff;
      if (op == OP_RESP && st.rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = code_ff;
         rsp_grant_in  = grant_ff;
         rsp_free_in   = free_sat;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         bytes_ff     <= HeapBytesReset;
         pending_ff   <= 1'b1;
         cnt_ff       <= CntOne;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         bytes_ff     <= bytes_in;
         pending_ff   <= pending_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      rem_ff        <= rem_in;
      range_bad_ff  <= range_bad_in;
      offset_ff     <= offset_in;
      free_sum_ff   <= free_sum_in;
      cur_ff        <= cur_in;
      code_ff       <= code_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_free_total      = rsp_free_ff;

   // The block count always stays between one and the table depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && (cnt_ff <= CntMax))
      else $error("block count out of range");

   // A reload leaves exactly one block in the table.
   a_load_one: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LOAD) |=> (cnt_ff == CntOne))
      else $error("reload did not leave one block");

   // A split entry is only inserted while the table has room.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (op == OP_IN_RD && !st.in_more) |-> (cnt_ff < CntMax))
      else $error("split inserted into a full table");

   // A word without success never carries an address.
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_DONE) |-> (rsp_grant_ff == '0))
      else $error("failed item reports an address");

endmodule

>>> rtl/first_fit_block_allocator_unit.sv
// First-fit heap block allocator. Each request word is handled alone. An
// allocate takes the word, visits table entries in order (read, latch,
// merge check, fit check for each) and then posts the result. When a visit
// merges two free entries, the entries behind them move down, each with a
// read and a write, and a last step ends the move. When a split inserts an
// entry, the entries behind it move up, each with a read and a write, and a
// last step writes the new entry. A release takes the word, reads and
// checks every entry visited and posts the result. An address out of range
// goes to the result in place of the walk. All of this is paced by the
// table memory, which gives one read and one write per cycle. After reset
// and after every write of the heap size register, the request side stalls
// while the table is reloaded. A finished result waits in an output
// register, so the next request can already be worked on while it is
// held. Posting a result waits as long as an earlier result is still held.
// ============================================================================
// first_fit_block_allocator_unit
// Top level: allocate and release requests against a first-fit block table.
// ============================================================================
module first_fit_block_allocator_unit #(
   parameter int MAX_BLOCKS   = ffba_pkg::DefMaxBlocks,
   parameter int HEADER_BYTES = ffba_pkg::DefHeaderBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_release_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted_address,
   output logic [31:0] rsp_free_total
);
   import ffba_pkg::*;

   op_type        op;
   dp_status_type st;

   // Sequencer.
   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .st        (st),
      .op        (op),
      .req_stall (req_stall)
   );

   // Table and arithmetic.
   ffba_dp #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .op                  (op),
      .st                  (st),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_kind            (req_kind),
      .req_request_bytes   (req_request_bytes),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_total      (rsp_free_total)
   );

endmodule
